@@ rtl/skvm_pkg.sv @@
// ----------------------------------------------------------------------------
// skvm_pkg
// shared types and constants for the sorted key/value map
// ----------------------------------------------------------------------------
package skvm_pkg;

   localparam int CAPACITY_DEFAULT  = 64;
   localparam int KEY_WIDTH_DEFAULT = 64;
   localparam int KEY_PORT_WIDTH    = 64;
   localparam int VALUE_WIDTH       = 32;
   localparam int MODE_WIDTH        = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_LOOKUP = 2'd2;

   localparam logic [VALUE_WIDTH-1:0] VALUE_ABSENT = {VALUE_WIDTH{1'b1}};

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } skvm_state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins_shift;
      logic overwrite;
      logic rem_shift;
   } skvm_cmd_type;

endpackage

@@ rtl/sorted_key_value_map.sv @@
// ----------------------------------------------------------------------------
// sorted_key_value_map
// sorted key/value store built as a row of compare-and-shift cells
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_mode, req_key, req_value            start high, busy low
//  response  rsp_result_value, rsp_found, rsp_status rsp_strobe, one cycle
//
//  an accepted word is latched, then in the execute state every cell compares
//  and shifts; the response word is registered at the same edge as the shift,
//  so a word takes the latch and a single compare-and-shift pass
//  busy is high for the one execute cycle; the next word may be accepted
//  while the response strobe is up
//  reset empties the store; the response side has no stall
// ----------------------------------------------------------------------------
module sorted_key_value_map import skvm_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [MODE_WIDTH-1:0]     req_mode,
   input  logic [KEY_PORT_WIDTH-1:0] req_key,
   input  logic [VALUE_WIDTH-1:0]    req_value,
   output logic                      rsp_strobe,
   output logic [VALUE_WIDTH-1:0]    rsp_result_value,
   output logic                      rsp_found,
   output logic                      rsp_status
);

   skvm_state_type state_ff, state_in;

   logic [MODE_WIDTH-1:0]  op_mode_ff;
   logic [KEY_WIDTH-1:0]   op_key_ff;
   logic [VALUE_WIDTH-1:0] op_value_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_status_ff, rsp_status_in;

   // neighbour chains: entry i+1 is cell i; vld/key/val ends are empty slots, lt_chain[0] is tied high
   logic                   lt_chain  [0:CAPACITY];
   logic                   vld_chain [0:CAPACITY+1];
   logic [KEY_WIDTH-1:0]   key_chain [0:CAPACITY+1];
   logic [VALUE_WIDTH-1:0] val_chain [0:CAPACITY+1];
   logic [VALUE_WIDTH-1:0] hit_vals  [0:CAPACITY-1];
   logic [CAPACITY-1:0]    cell_eq;
   logic [CAPACITY-1:0]    cell_vld;

   logic                   accept;
   logic                   exec;
   logic                   present;
   logic                   full;
   logic                   is_ins;
   logic                   is_rem;
   logic                   vld_hole;
   logic [VALUE_WIDTH-1:0] hit_any;
   skvm_cmd_type           cmd;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);
   assign busy   = exec;

   assign lt_chain[0]           = 1'b1;
   assign vld_chain[0]          = 1'b0;
   assign key_chain[0]          = '0;
   assign val_chain[0]          = '0;
   assign vld_chain[CAPACITY+1] = 1'b0;
   assign key_chain[CAPACITY+1] = '0;
   assign val_chain[CAPACITY+1] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         skvm_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .op_key    (op_key_ff),
            .op_value  (op_value_ff),
            .left_lt   (lt_chain[gi]),
            .left_vld  (vld_chain[gi]),
            .left_key  (key_chain[gi]),
            .left_val  (val_chain[gi]),
            .right_vld (vld_chain[gi+2]),
            .right_key (key_chain[gi+2]),
            .right_val (val_chain[gi+2]),
            .lt        (lt_chain[gi+1]),
            .eq        (cell_eq[gi]),
            .vld       (vld_chain[gi+1]),
            .key       (key_chain[gi+1]),
            .val       (val_chain[gi+1]),
            .hit_val   (hit_vals[gi])
         );
         assign cell_vld[gi] = vld_chain[gi+1];
      end
   endgenerate

   always_comb begin
      hit_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_any = hit_any | hit_vals[i];
      end
   end

   assign present  = |cell_eq;
   assign full     = cell_vld[CAPACITY-1];
   assign is_ins   = (op_mode_ff == MODE_INSERT);
   assign is_rem   = (op_mode_ff == MODE_REMOVE);
   assign vld_hole = |(cell_vld[CAPACITY-1:1] & ~cell_vld[CAPACITY-2:0]);

   assign cmd.ins_shift = exec && is_ins && !present && !full;
   assign cmd.overwrite = exec && is_ins && present;
   assign cmd.rem_shift = exec && is_rem && present;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_found_in  = present;
            if (is_ins) begin
               rsp_value_in  = '0;
               rsp_status_in = !present && full;
            end else begin
               rsp_value_in  = present ? hit_any : VALUE_ABSENT;
               rsp_status_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_mode_ff  <= req_mode;
         op_key_ff   <= req_key[KEY_WIDTH-1:0];
         op_value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;

   // assertions
   a_exec_gives_word: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_strobe_ff)
      else $error("execute cycle gave no response word");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not start execution");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff) |-> !rsp_found_ff)
      else $error("full status on a key that was present");

   a_store_packed: assert property (@(posedge clock) disable iff (reset)
      !vld_hole)
      else $error("occupied slots are not contiguous");

endmodule

@@ rtl/skvm_cell.sv @@
// ----------------------------------------------------------------------------
// skvm_cell
// one slot of the sorted store: compares against the operand key and takes
// its next pair from itself, the operand, or a neighbour
// ----------------------------------------------------------------------------
module skvm_cell import skvm_pkg::*; #(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  skvm_cmd_type           cmd,
   input  logic [KEY_WIDTH-1:0]   op_key,
   input  logic [VALUE_WIDTH-1:0] op_value,
   input  logic                   left_lt,
   input  logic                   left_vld,
   input  logic [KEY_WIDTH-1:0]   left_key,
   input  logic [VALUE_WIDTH-1:0] left_val,
   input  logic                   right_vld,
   input  logic [KEY_WIDTH-1:0]   right_key,
   input  logic [VALUE_WIDTH-1:0] right_val,
   output logic                   lt,
   output logic                   eq,
   output logic                   vld,
   output logic [KEY_WIDTH-1:0]   key,
   output logic [VALUE_WIDTH-1:0] val,
   output logic [VALUE_WIDTH-1:0] hit_val
);

   logic                   vld_ff, vld_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;

   assign lt      = vld_ff && (key_ff < op_key);
   assign eq      = vld_ff && (key_ff == op_key);
   assign vld     = vld_ff;
   assign key     = key_ff;
   assign val     = val_ff;
   assign hit_val = eq ? val_ff : '0;

   always_comb begin
      vld_in = vld_ff;
      key_in = key_ff;
      val_in = val_ff;
      if (cmd.ins_shift && !lt) begin
         if (left_lt) begin
            // insertion point
            vld_in = 1'b1;
            key_in = op_key;
            val_in = op_value;
         end else begin
            vld_in = left_vld;
            key_in = left_key;
            val_in = left_val;
         end
      end
      if (cmd.rem_shift && !lt) begin
         vld_in = right_vld;
         key_in = right_key;
         val_in = right_val;
      end
      if (cmd.overwrite && eq) begin
         val_in = op_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
   end

endmodule

@@ bench/sorted_key_value_map_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_value_map_test
// self-checking bench for the sorted key/value map
// ----------------------------------------------------------------------------
//  a queue of command words feeds a clocked driver; every accepted word is run
//  through a local sorted-array model of the map and the reply it should give
//  is queued; a clocked monitor compares each strobed reply field by field.
//  a short directed run covers the empty store, extreme keys and values,
//  overwrite, absent keys and the unused mode; three random phases then
//  fill the store past capacity, mix operations at full and drain it again,
//  with the sender idling 14, 79 and 0 percent of the time
// ----------------------------------------------------------------------------
module sorted_key_value_map_test;
   import skvm_pkg::*;

   localparam int MAP_SLOTS   = CAPACITY_DEFAULT;
   localparam int POOL_SIZE   = 72;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]     mode;
      logic [KEY_PORT_WIDTH-1:0] key;
      logic [VALUE_WIDTH-1:0]    value;
   } map_word_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] result_value;
      logic                   found;
      logic                   status;
   } map_reply_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [MODE_WIDTH-1:0]     req_mode = '0;
   logic [KEY_PORT_WIDTH-1:0] req_key = '0;
   logic [VALUE_WIDTH-1:0]    req_value = '0;
   logic                      rsp_strobe;
   logic [VALUE_WIDTH-1:0]    rsp_result_value;
   logic                      rsp_found;
   logic                      rsp_status;

   logic [KEY_PORT_WIDTH-1:0] map_keys [MAP_SLOTS];
   logic [VALUE_WIDTH-1:0]    map_values [MAP_SLOTS];
   int                        stored_count = 0;

   map_word_type              pending_words [$];
   map_reply_type             expected_replies [$];
   logic [KEY_PORT_WIDTH-1:0] key_pool [POOL_SIZE];
   int                        sender_idle_pct = 14;
   int                        errors = 0;
   int                        cycle_count = 0;

   sorted_key_value_map DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status)
   );

   always #4 clock = ~clock;

   // lower-bound search, then insert, remove or look up
   function automatic map_reply_type apply_word(input map_word_type w);
      map_reply_type reply;
      int            pos;
      int            span;
      int            half;
      int            probe;
      logic          present;
      pos  = 0;
      span = stored_count;
      while (span > 0) begin
         half  = span >> 1;
         probe = pos + half;
         if (map_keys[probe] < w.key) begin
            pos  = probe + 1;
            span = span - half - 1;
         end else begin
            span = half;
         end
      end
      present = (pos < stored_count) && (map_keys[pos] == w.key);
      reply.result_value = VALUE_ABSENT;
      reply.found        = present;
      reply.status       = 1'b0;
      case (w.mode)
         MODE_INSERT: begin
            reply.result_value = '0;
            if (present) begin
               map_values[pos] = w.value;
            end else if (stored_count >= MAP_SLOTS) begin
               reply.status = 1'b1;
            end else begin
               for (int i = stored_count; i > pos; i--) begin
                  map_keys[i]   = map_keys[i-1];
                  map_values[i] = map_values[i-1];
               end
               map_keys[pos]   = w.key;
               map_values[pos] = w.value;
               stored_count++;
            end
         end
         MODE_REMOVE: begin
            if (present) begin
               reply.result_value = map_values[pos];
               for (int i = pos; i + 1 < stored_count; i++) begin
                  map_keys[i]   = map_keys[i+1];
                  map_values[i] = map_values[i+1];
               end
               stored_count--;
            end
         end
         default: begin
            if (present) reply.result_value = map_values[pos];
         end
      endcase
      return reply;
   endfunction

   function automatic logic [KEY_PORT_WIDTH-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   task automatic push_word(input logic [MODE_WIDTH-1:0] mode,
                            input logic [KEY_PORT_WIDTH-1:0] key,
                            input logic [VALUE_WIDTH-1:0] value);
      map_word_type w;
      w.mode  = mode;
      w.key   = key;
      w.value = value;
      pending_words.push_back(w);
   endtask

   task automatic build_pool();
      logic [31:0] shared_high;
      shared_high = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      // odd entries from index 3 share their upper half so ordering hinges on the low word
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = (i % 2 == 1) ? {shared_high, $urandom} : random_key();
   endtask

   task automatic mixed_words(input int count);
      logic [KEY_PORT_WIDTH-1:0] key;
      int                        pick;
      repeat (count) begin
         key  = ($urandom_range(9) == 0) ? random_key()
                                         : key_pool[$urandom_range(POOL_SIZE-1)];
         pick = $urandom_range(99);
         if (pick < 40)      push_word(MODE_INSERT, key, $urandom);
         else if (pick < 70) push_word(MODE_REMOVE, key, $urandom);
         else if (pick < 95) push_word(MODE_LOOKUP, key, $urandom);
         else                push_word(MODE_SPARE, key, $urandom);
      end
   endtask

   // every pool key once, in shuffled order
   task automatic sweep_pool(input logic [MODE_WIDTH-1:0] mode);
      logic [KEY_PORT_WIDTH-1:0] order [POOL_SIZE];
      logic [KEY_PORT_WIDTH-1:0] swap;
      int                        j;
      order = key_pool;
      for (int i = POOL_SIZE - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < POOL_SIZE; i++) push_word(mode, order[i], $urandom);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : drive
      map_word_type next_word;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_replies.push_back(apply_word({req_mode, req_key, req_value}));
         if (!start || !busy) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_word = pending_words.pop_front();
               start     <= 1'b1;
               req_mode  <= next_word.mode;
               req_key   <= next_word.key;
               req_value <= next_word.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check
      map_reply_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected reply word: result_value %h found %b status %b",
                   rsp_result_value, rsp_found, rsp_status);
            errors++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_result_value !== want.result_value) begin
               $error("result_value: expected %h, actual %h",
                      want.result_value, rsp_result_value);
               errors++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %b, actual %b", want.found, rsp_found);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %b, actual %b", want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int phase_idle [3];
      phase_idle = '{14, 79, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_word(MODE_LOOKUP, '0, $urandom);
      push_word(MODE_REMOVE, '0, $urandom);
      push_word(MODE_SPARE, '0, $urandom);
      push_word(MODE_INSERT, '0, 32'h8000_0000);
      push_word(MODE_INSERT, '1, 32'h7fff_ffff);
      push_word(MODE_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0001);
      push_word(MODE_INSERT, 64'd1, 32'h0000_0000);
      push_word(MODE_INSERT, '0, 32'hffff_ffff);
      push_word(MODE_LOOKUP, '0, $urandom);
      push_word(MODE_LOOKUP, '1, $urandom);
      push_word(MODE_LOOKUP, 64'd2, $urandom);
      push_word(MODE_SPARE, 64'd1, $urandom);
      push_word(MODE_SPARE, 64'd2, $urandom);
      push_word(MODE_REMOVE, 64'h8000_0000_0000_0000, $urandom);
      push_word(MODE_REMOVE, 64'h8000_0000_0000_0000, $urandom);
      push_word(MODE_REMOVE, '1, $urandom);
      push_word(MODE_REMOVE, '0, $urandom);
      push_word(MODE_LOOKUP, 64'd1, $urandom);
      push_word(MODE_REMOVE, 64'd1, $urandom);
      push_word(MODE_LOOKUP, 64'd1, $urandom);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = phase_idle[phase];
         build_pool();
         mixed_words(110);
         sweep_pool(MODE_INSERT);
         mixed_words(70);
         sweep_pool(MODE_REMOVE);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
